// ----- sv/password_line_entry_with_lockout_unit_defines.svh -----
// assertion macros for the password line entry unit
// used by the top level only; no other dependencies
`ifndef PASSWORD_LINE_ENTRY_WITH_LOCKOUT_UNIT_DEFINES_SVH
`define PASSWORD_LINE_ENTRY_WITH_LOCKOUT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define PLEL_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PLEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PLEL_ASSERT_HOLDS(lbl, cond, msg)
`define PLEL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/plel_pkg.sv -----
// shared types, character codes and configuration constants
// for the password line entry unit; no dependencies
package plel_pkg;

    localparam int LINE_LIMIT_DEF = 14;
    localparam int CFG_DATA_W     = 56;
    localparam int CFG_IDX_W      = 2;
    localparam int PW_LEN_W       = 4;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [PW_LEN_W-1:0] ATTEMPT_LIMIT_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PW_HEAD   = 2'd0,
        CFG_PW_TAIL   = 2'd1,
        CFG_PW_LENGTH = 2'd2,
        CFG_ATT_LIMIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_GRANTED = 2'd1,
        VERDICT_DENIED  = 2'd2,
        VERDICT_LOCKOUT = 2'd3
    } verdict_t;

    // one result burst: a single beat, or BS/space/BS when bs_burst is set
    typedef struct packed {
        logic       bs_burst;
        logic [7:0] out_byte;
        verdict_t   verdict;
    } desc_t;

endpackage

// ----- sv/plel_core.sv -----
// input register, line store, password compare and attempt counter
// depends on plel_pkg
module plel_core #(
    parameter int LINE_LIMIT = plel_pkg::LINE_LIMIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    input  logic                           cfg_wr_en,
    input  logic [plel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plel_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           take,
    output logic                           desc_valid,
    output plel_pkg::desc_t                desc
);
    import plel_pkg::*;

    localparam int LEN_W = $clog2(LINE_LIMIT + 1);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic [CFG_DATA_W-1:0] pw_head_reg;
    logic [CFG_DATA_W-1:0] pw_tail_reg;
    logic [PW_LEN_W-1:0]   pw_len_reg;
    logic [PW_LEN_W-1:0]   limit_reg;
    logic [LEN_W-1:0]      line_len_reg;
    logic [LEN_W-1:0]      line_len_next;
    logic [PW_LEN_W-1:0]   fails_reg;
    logic [PW_LEN_W-1:0]   fails_next;
    logic [PW_LEN_W-1:0]   fails_inc;
    logic                  granted_reg;
    logic                  granted_next;
    logic [7:0]            store_reg [LINE_LIMIT];
    logic [LINE_LIMIT-1:0] lane_ok;
    logic [2*CFG_DATA_W-1:0] pw_all;
    logic                  fire;
    logic                  store_we;
    logic                  match;
    logic                  has_room;

    assign fire    = in_valid_reg && take;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_head_reg <= '0;
            pw_tail_reg <= '0;
            pw_len_reg  <= '0;
            limit_reg   <= ATTEMPT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PW_HEAD:   pw_head_reg <= cfg_data;
                CFG_PW_TAIL:   pw_tail_reg <= cfg_data;
                CFG_PW_LENGTH: pw_len_reg  <= cfg_data[PW_LEN_W-1:0];
                CFG_ATT_LIMIT: limit_reg   <= cfg_data[PW_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // one compare lane per character; lanes past the line length always pass
    assign pw_all = {pw_tail_reg, pw_head_reg};

    for (genvar i = 0; i < LINE_LIMIT; i++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (store_we && line_len_reg == LEN_W'(i)) begin
                store_reg[i] <= in_byte_reg;
            end
        end
        assign lane_ok[i] = (LEN_W'(i) >= line_len_reg) || (store_reg[i] == pw_all[8*i +: 8]);
    end

    assign match     = (PW_LEN_W'(line_len_reg) == pw_len_reg) && (&lane_ok);
    assign has_room  = line_len_reg < LEN_W'(LINE_LIMIT);
    assign fails_inc = fails_reg + PW_LEN_W'(1);

    always_comb begin
        line_len_next = line_len_reg;
        fails_next    = fails_reg;
        granted_next  = granted_reg;
        store_we      = 1'b0;
        desc_valid    = 1'b0;
        desc.bs_burst = 1'b0;
        desc.out_byte = in_byte_reg;
        desc.verdict  = VERDICT_NONE;
        if (fire && !granted_reg) begin
            if (in_byte_reg == CH_BS) begin
                if (line_len_reg != '0) begin
                    line_len_next = line_len_reg - LEN_W'(1);
                    desc_valid    = 1'b1;
                    desc.bs_burst = 1'b1;
                    desc.out_byte = CH_BS;
                end
            end else if (in_byte_reg == CH_CR || in_byte_reg == CH_LF) begin
                line_len_next = '0;
                desc_valid    = 1'b1;
                desc.out_byte = CH_LF;
                if (match) begin
                    granted_next = 1'b1;
                    desc.verdict = VERDICT_GRANTED;
                end else if (fails_inc >= limit_reg) begin
                    fails_next   = '0;
                    desc.verdict = VERDICT_LOCKOUT;
                end else begin
                    fails_next   = fails_inc;
                    desc.verdict = VERDICT_DENIED;
                end
            end else if (has_room) begin
                store_we      = 1'b1;
                line_len_next = line_len_reg + LEN_W'(1);
                desc_valid    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= '0;
            fails_reg    <= '0;
            granted_reg  <= 1'b0;
        end else begin
            line_len_reg <= line_len_next;
            fails_reg    <= fails_next;
            granted_reg  <= granted_next;
        end
    end

endmodule

// ----- sv/plel_out.sv -----
// result register and beat sequencer for one- or three-beat bursts
// depends on plel_pkg
module plel_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            desc_valid,
    input  plel_pkg::desc_t desc,
    output logic            take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_verdict,
    output logic            m_last
);
    import plel_pkg::*;

    localparam logic [1:0] BEAT_SP   = 2'd1;
    localparam logic [1:0] BEAT_LAST = 2'd2;

    logic       busy_reg;
    logic       bs_reg;
    logic [7:0] byte_reg;
    verdict_t   verdict_reg;
    logic [1:0] beat_reg;

    assign m_valid    = busy_reg;
    assign m_last     = !bs_reg || beat_reg == BEAT_LAST;
    assign m_verdict  = verdict_reg;
    assign m_out_byte = (bs_reg && beat_reg == BEAT_SP) ? CH_SP : byte_reg;
    // free for the next burst once the final beat of this one goes
    assign take       = !busy_reg || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (take) begin
            busy_reg <= desc_valid;
            beat_reg <= '0;
        end else if (m_ready) begin
            beat_reg <= beat_reg + 2'd1;
        end
        if (take) begin
            bs_reg      <= desc.bs_burst;
            byte_reg    <= desc.out_byte;
            verdict_reg <= desc.verdict;
        end
    end

endmodule

// ----- sv/password_line_entry_with_lockout_unit.sv -----
// top level of the password line entry unit with attempt lockout
// depends on plel_pkg, plel_core, plel_out and the assertion macro header
`include "password_line_entry_with_lockout_unit_defines.svh"

// Takes terminal bytes on s_* and returns echo beats on m_*. An ordinary byte
// is echoed while the line has room, a backspace on a non-empty line gives the
// three beats BS, space, BS, and CR or LF gives one LF beat carrying the
// verdict. Every beat of a burst but the final one has m_last low. A byte goes
// through an input register and the compare logic into the result register;
// its first beat is driven from the result register. A byte can be accepted
// in every cycle while the result side keeps up; a backspace holds the result
// register for three beats, during which at most one more byte is taken.
// Once access is granted all bytes are accepted and dropped until reset.
// Configuration writes are taken at once and must only occur while idle.
module password_line_entry_with_lockout_unit #(
    parameter int LINE_LIMIT = plel_pkg::LINE_LIMIT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic [1:0]                      m_verdict,
    output logic                            m_last,
    input  logic                            cfg_wr_en,
    input  logic [plel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plel_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plel_pkg::*;

    logic  take;
    logic  desc_valid;
    desc_t desc;

    plel_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    plel_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_verdict  (m_verdict),
        .m_last     (m_last)
    );

    // a verdict only ever rides on the closing LF beat
    `PLEL_ASSERT_HOLDS(a_verdict_on_lf, !m_valid || m_verdict == VERDICT_NONE || (m_out_byte == CH_LF && m_last), "verdict outside LF beat")

    // a burst that is not finished keeps its beats coming
    `PLEL_ASSERT_NEXT(a_burst_continues, m_valid && m_ready && !m_last, m_valid, "burst cut short")

    // after a granted beat goes out nothing more is produced
    `PLEL_ASSERT_NEXT(a_silent_after_grant, m_valid && m_ready && m_verdict == VERDICT_GRANTED, !m_valid, "output after grant")

endmodule

// ----- sim/tb_password_line_entry_with_lockout_unit.sv -----
// self-checking bench for password_line_entry_with_lockout_unit: random terminal bytes,
// register writes between phases, echo beats and verdicts checked in a scoreboard class
// depends on plel_pkg and the unit's rtl
import plel_pkg::*;

typedef struct packed {
    logic [7:0] out_byte;
    verdict_t   verdict;
    logic       last;
} echo_beat_t;

class line_entry_scoreboard;
    logic [CFG_DATA_W-1:0] pw_head;
    logic [CFG_DATA_W-1:0] pw_tail;
    logic [3:0]            pw_len;
    logic [3:0]            attempt_cap;
    logic [7:0]            typed [LINE_LIMIT_DEF];
    int unsigned           typed_len;
    logic [3:0]            fail_count;
    bit                    unlocked;
    echo_beat_t            awaited [$];
    int unsigned           bytes_noted, beats_checked, mismatches;
    int unsigned           n_denied, n_lockout, n_granted, n_rubout, n_silent;

    function new();
        pw_head       = '0;
        pw_tail       = '0;
        pw_len        = '0;
        attempt_cap   = ATTEMPT_LIMIT_RST;
        typed_len     = 0;
        fail_count    = '0;
        unlocked      = 1'b0;
        bytes_noted   = 0;
        beats_checked = 0;
        mismatches    = 0;
        n_denied      = 0;
        n_lockout     = 0;
        n_granted     = 0;
        n_rubout      = 0;
        n_silent      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PW_HEAD:   pw_head = value;
            CFG_PW_TAIL:   pw_tail = value;
            CFG_PW_LENGTH: pw_len = value[3:0];
            CFG_ATT_LIMIT: attempt_cap = value[3:0];
            default: ;
        endcase
    endfunction

    function logic [7:0] pw_char(int unsigned i);
        if (i < 7)
            return pw_head[8*i +: 8];
        return pw_tail[8*(i-7) +: 8];
    endfunction

    function bit would_grant();
        if (unlocked || typed_len != pw_len)
            return 1'b0;
        for (int unsigned i = 0; i < typed_len; i++)
            if (typed[i] != pw_char(i))
                return 1'b0;
        return 1'b1;
    endfunction

    function void push_beat(logic [7:0] b, verdict_t v, logic l);
        echo_beat_t e;
        e.out_byte = b;
        e.verdict  = v;
        e.last     = l;
        awaited.push_back(e);
    endfunction

    function void note_byte(logic [7:0] b);
        verdict_t v;
        bytes_noted++;
        if (unlocked) begin
            n_silent++;
            return;
        end
        if (b == CH_BS) begin
            if (typed_len == 0) begin
                n_silent++;
                return;
            end
            typed_len--;
            n_rubout++;
            push_beat(CH_BS, VERDICT_NONE, 1'b0);
            push_beat(CH_SP, VERDICT_NONE, 1'b0);
            push_beat(CH_BS, VERDICT_NONE, 1'b1);
        end else if (b == CH_CR || b == CH_LF) begin
            if (would_grant()) begin
                unlocked = 1'b1;
                v = VERDICT_GRANTED;
                n_granted++;
            end else begin
                fail_count = fail_count + 4'd1;
                if (fail_count >= attempt_cap) begin
                    fail_count = '0;
                    v = VERDICT_LOCKOUT;
                    n_lockout++;
                end else begin
                    v = VERDICT_DENIED;
                    n_denied++;
                end
            end
            typed_len = 0;
            push_beat(CH_LF, v, 1'b1);
        end else if (typed_len < LINE_LIMIT_DEF) begin
            typed[typed_len] = b;
            typed_len++;
            push_beat(b, VERDICT_NONE, 1'b1);
        end else begin
            n_silent++;
        end
    endfunction

    function void check_beat(logic [7:0] b, logic [1:0] v, logic l);
        echo_beat_t want;
        beats_checked++;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: beat %02h verdict %0d last %0b with nothing expected",
                         b, v, l);
            return;
        end
        want = awaited.pop_front();
        if (want.out_byte !== b || want.verdict !== v || want.last !== l) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at beat %0d: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                         beats_checked, want.out_byte, want.verdict, want.last, b, v, l);
        end
    endfunction
endclass

module tb_password_line_entry_with_lockout_unit;
    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 90;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_out_byte;
    logic [1:0]            m_verdict;
    logic                  m_last;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    line_entry_scoreboard sb = new();
    bit quick_send;
    bit quick_recv;
    bit grant_ok;

    password_line_entry_with_lockout_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_verdict  (m_verdict),
        .m_last     (m_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD/2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout with %0d beats still awaited", sb.awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_beat(m_out_byte, m_verdict, m_last);
    end

    // result side: random stalls per beat, two long hold-offs to back the block up
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken   = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 25 == 0)
                quick_recv = ($urandom_range(0, 3) == 0);
            if (taken == 40 || taken == 250)
                stall = HOLD_CYCLES;
            else
                stall = quick_recv ? 0 : $urandom_range(0, 5);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            taken++;
        end
    end

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_BS || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand56();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] typeable_word();
        logic [CFG_DATA_W-1:0] w;
        for (int i = 0; i < 7; i++)
            w[8*i +: 8] = rand_char();
        return w;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (sb.bytes_noted % 25 == 0)
            quick_send = ($urandom_range(0, 3) == 0);
        gap = quick_send ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_byte(b);
    endtask

    // a line end that would unlock too early is spoilt by one more keystroke
    task automatic key(input logic [7:0] b);
        if ((b == CH_CR || b == CH_LF) && !grant_ok && sb.would_grant())
            push_byte(sb.typed_len != 0 ? CH_BS : 8'h61);
        push_byte(b);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] head, input logic [CFG_DATA_W-1:0] tail,
                             input logic [3:0] len, input logic [3:0] cap);
        write_reg(CFG_PW_HEAD, head);
        write_reg(CFG_PW_TAIL, tail);
        write_reg(CFG_PW_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_ATT_LIMIT, CFG_DATA_W'(cap));
    endtask

    // variant 0 exact, 1 one character altered, 2 one short, otherwise one extra
    task automatic type_attempt(input int unsigned variant);
        logic [7:0]  word [$];
        int unsigned n;
        int unsigned pos;
        n = sb.pw_len;
        for (int unsigned i = 0; i < n; i++)
            word.push_back(sb.pw_char(i));
        case (variant)
            0: ;
            1: if (n != 0) begin
                pos = $urandom_range(0, n - 1);
                word[pos] ^= 8'($urandom_range(1, 255));
            end else begin
                word.push_back(rand_char());
            end
            2: if (n != 0) void'(word.pop_back());
               else word.push_back(rand_char());
            default: word.push_back(rand_char());
        endcase
        if (grant_ok || $urandom_range(0, 3) != 0)
            while (sb.typed_len != 0) key(CH_BS);
        foreach (word[k]) begin
            // typo corrected straight away
            if ($urandom_range(0, 7) == 0) begin
                key(rand_char());
                key(CH_BS);
            end
            key(word[k]);
        end
        key($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task automatic noise(input int unsigned count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                key(CH_BS);
            else if (r == 1)
                key(CH_CR);
            else if (r == 2)
                key(CH_LF);
            else
                key(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned r;
        stop_at = sb.bytes_noted + quota;
        while (sb.bytes_noted < stop_at) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                type_attempt($urandom_range(0, 3));
            end else if (r < 9) begin
                noise($urandom_range(1, 6));
            end else begin
                // run past the end of the line
                repeat ($urandom_range(14, 18)) key(rand_char());
                key(CH_CR);
            end
        end
    endtask

    initial begin : stimulus
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PW_HEAD;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        grant_ok  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty password, lockout on the third failure
        key(CH_BS);
        key(8'h00);
        key(8'hFF);
        key(CH_BS);
        key(8'h80);
        key(CH_CR);
        key(8'h7F);
        key(CH_LF);
        key(8'h01);
        key(CH_CR);
        drain();

        // full-length password, single attempt; one byte too many on the line
        configure(typeable_word(), typeable_word(), 4'd14, 4'd1);
        for (int i = 0; i < 15; i++)
            key(i == 3 ? 8'h00 : rand_char());
        key(CH_BS);
        key(CH_CR);
        drain();

        configure(rand56(), rand56(), 4'd14, 4'd15);
        random_phase(60);
        drain();
        configure(rand56(), '0, 4'd1, 4'd1);
        random_phase(60);
        drain();
        configure(rand56(), rand56(), 4'd0, 4'($urandom_range(1, 15)));
        random_phase(30);
        drain();
        random_phase(30);
        drain();
        configure('1, '1, 4'($urandom_range(1, 14)), 4'($urandom_range(1, 15)));
        random_phase(60);
        drain();
        configure(rand56(), rand56(), 4'($urandom_range(0, 14)), 4'($urandom_range(1, 15)));
        random_phase(60);
        drain();

        // last setting: typeable password, then the right line and bytes that go nowhere
        configure(typeable_word(), typeable_word(), 4'($urandom_range(1, 14)),
                  4'($urandom_range(1, 15)));
        random_phase(25);
        grant_ok = 1'b1;
        type_attempt(0);
        repeat (12) key(8'($urandom_range(0, 255)));
        drain();

        $display("%0d bytes in, %0d beats checked: %0d denied, %0d lockouts, %0d granted",
                 sb.bytes_noted, sb.beats_checked, sb.n_denied, sb.n_lockout, sb.n_granted);
        $display("%0d backspace bursts, %0d bytes dropped or ignored, %0d mismatches",
                 sb.n_rubout, sb.n_silent, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
